[hw/rtl/r2y_pkg.sv]
`timescale 1ns / 1ps

package r2y_pkg;

    // Fixed field widths
    localparam int SIZE_W     = 11;
    localparam int PIX_W      = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int LIDX_W     = 20;
    localparam int CIDX_W     = 18;
    localparam int NUM_W      = 15;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 8'd1;

    // Reset sizes
    localparam logic [SIZE_W-1:0] RST_WIDTH  = 11'd352;
    localparam logic [SIZE_W-1:0] RST_HEIGHT = 11'd288;

    // Divide by 100: q = (n * 5243) >> 19, exact for n below 43690
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int          RECIP_SH  = 19;

    // Classified pixel passed from front to back
    typedef struct packed {
        logic [PIX_W-1:0]  red;
        logic [PIX_W-1:0]  green;
        logic [PIX_W-1:0]  blue;
        logic [SIZE_W-1:0] col;
        logic [SIZE_W-1:0] row;
        logic [SIZE_W-1:0] width;
        logic              chroma_valid;
        logic              frame_end;
    } t_item;

    // Queue status seen by the producer and consumer
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

[hw/rtl/r2y_front.sv]
`timescale 1ns / 1ps

module r2y_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [r2y_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [r2y_pkg::SIZE_W-1:0]        i_cfg_data,
    output logic                              o_cfg_ready,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [r2y_pkg::PIX_W-1:0]         i_red,
    input  logic [r2y_pkg::PIX_W-1:0]         i_green,
    input  logic [r2y_pkg::PIX_W-1:0]         i_blue,
    input  r2y_pkg::t_q_status                i_q_status,
    output logic                              o_push,
    output r2y_pkg::t_item                    o_item
);
    import r2y_pkg::*;

    localparam logic [12:0] LIM_W = 13'(MAX_WIDTH - (MAX_WIDTH % 2));
    localparam logic [12:0] LIM_H = 13'(MAX_HEIGHT - (MAX_HEIGHT % 2));

    logic [SIZE_W-1:0] r_width, n_width;
    logic [SIZE_W-1:0] r_height, n_height;
    logic [SIZE_W-1:0] r_col, n_col;
    logic [SIZE_W-1:0] r_row, n_row;
    logic              col_last;
    logic              row_last;
    logic              accept;
    logic              cfg_hit;

    // Even, at least two, at most the limit
    function automatic logic [SIZE_W-1:0] f_eff(input logic [SIZE_W-1:0] raw,
                                                input logic [12:0] lim);
        logic [12:0] s;
        s = {2'b00, raw[SIZE_W-1:1], 1'b0};
        if (s < 13'd2) s = 13'd2;
        if (s > lim) s = lim;
        return s[SIZE_W-1:0];
    endfunction

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !i_q_status.full;
    assign accept      = i_valid && o_ready;
    assign o_push      = accept;
    assign cfg_hit     = i_cfg_valid &&
                         (i_cfg_index == REG_FRAME_WIDTH || i_cfg_index == REG_FRAME_HEIGHT);

    assign col_last = ({1'b0, r_col} + 12'd1) >= {1'b0, r_width};
    assign row_last = ({1'b0, r_row} + 12'd1) >= {1'b0, r_height};

    // Classify the pixel from its position
    always_comb begin
        o_item.red          = i_red;
        o_item.green        = i_green;
        o_item.blue         = i_blue;
        o_item.col          = r_col;
        o_item.row          = r_row;
        o_item.width        = r_width;
        o_item.chroma_valid = r_col[0] & r_row[0];
        o_item.frame_end    = col_last & row_last;
    end

    // Size registers and raster position
    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        n_col    = r_col;
        n_row    = r_row;
        if (cfg_hit) begin
            if (i_cfg_index == REG_FRAME_WIDTH) begin
                n_width = f_eff(i_cfg_data, LIM_W);
            end else begin
                n_height = f_eff(i_cfg_data, LIM_H);
            end
            n_col = '0;
            n_row = '0;
        end else if (accept) begin
            if (col_last) begin
                n_col = '0;
                n_row = row_last ? '0 : r_row + SIZE_W'(1);
            end else begin
                n_col = r_col + SIZE_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= f_eff(RST_WIDTH, LIM_W);
            r_height <= f_eff(RST_HEIGHT, LIM_H);
            r_col    <= '0;
            r_row    <= '0;
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
            r_col    <= n_col;
            r_row    <= n_row;
        end
    end

endmodule

[hw/rtl/r2y_queue.sv]
`timescale 1ns / 1ps

module r2y_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  r2y_pkg::t_item     i_item,
    input  logic               i_pop,
    output r2y_pkg::t_item     o_item,
    output r2y_pkg::t_q_status o_status
);
    import r2y_pkg::*;

    t_item       r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count, n_count;

    assign o_item         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) n_count = r_count + 2'd1;
        else if (!i_push && i_pop) n_count = r_count - 2'd1;
    end

    // Two-entry storage, no reset on payload
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= !r_wr_ptr;
            if (i_pop)  r_rd_ptr <= !r_rd_ptr;
            r_count <= n_count;
        end
    end

endmodule

[hw/rtl/r2y_back.sv]
`timescale 1ns / 1ps

module r2y_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  r2y_pkg::t_item                 i_item,
    input  r2y_pkg::t_q_status             i_q_status,
    output logic                           o_pop,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [r2y_pkg::PIX_W-1:0]      o_luma,
    output logic [r2y_pkg::LIDX_W-1:0]     o_luma_index,
    output logic                           o_chroma_valid,
    output logic [r2y_pkg::PIX_W-1:0]      o_chroma_u,
    output logic [r2y_pkg::PIX_W-1:0]      o_chroma_v,
    output logic [r2y_pkg::CIDX_W-1:0]     o_chroma_index,
    output logic                           o_frame_end
);
    import r2y_pkg::*;

    localparam int PROD_W = NUM_W + 13;

    logic adv;

    // Stage 1: numerators and index products
    logic                r_v1;
    logic [NUM_W-1:0]    r_s1_ln, r_s1_un, r_s1_vn;
    logic [21:0]         r_s1_lprod;
    logic [19:0]         r_s1_cprod;
    logic [SIZE_W-1:0]   r_s1_col;
    logic                r_s1_cv, r_s1_end;
    logic [15:0]         n_ln, n_un, n_vn;
    logic [15:0]         red_e, green_e, blue_e;

    // Stage 2: reciprocal products and index sums
    logic                r_v2;
    logic [PROD_W-1:0]   r_s2_lq, r_s2_uq, r_s2_vq;
    logic [LIDX_W-1:0]   r_s2_lidx;
    logic [CIDX_W-1:0]   r_s2_cidx;
    logic                r_s2_cv, r_s2_end;
    logic [22:0]         n_lidx;
    logic [20:0]         n_cidx;

    // Stage 3: output register
    logic                r_v3;

    assign adv     = !r_v3 || i_ready;
    assign o_pop   = adv && !i_q_status.empty;
    assign o_valid = r_v3;

    assign red_e   = {8'd0, i_item.red};
    assign green_e = {8'd0, i_item.green};
    assign blue_e  = {8'd0, i_item.blue};

    // Numerators stay non-negative, so modulo-2^16 arithmetic gives the true value
    always_comb begin
        n_ln = 16'd30 * red_e + 16'd59 * green_e + 16'd11 * blue_e;
        n_un = 16'd50 * blue_e + 16'd12800 - 16'd17 * red_e - 16'd33 * green_e;
        n_vn = 16'd50 * red_e + 16'd12800 - 16'd42 * green_e - 16'd8 * blue_e;
    end

    assign n_lidx = {1'b0, r_s1_lprod} + {12'd0, r_s1_col};
    assign n_cidx = {1'b0, r_s1_cprod} + {11'd0, r_s1_col[SIZE_W-1:1]};

    // Control of the three stages, all advancing together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v1 <= o_pop;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_ln    <= n_ln[NUM_W-1:0];
            r_s1_un    <= n_un[NUM_W-1:0];
            r_s1_vn    <= n_vn[NUM_W-1:0];
            r_s1_lprod <= {11'd0, i_item.row} * {11'd0, i_item.width};
            r_s1_cprod <= {10'd0, i_item.row[SIZE_W-1:1]} *
                          {10'd0, i_item.width[SIZE_W-1:1]};
            r_s1_col   <= i_item.col;
            r_s1_cv    <= i_item.chroma_valid;
            r_s1_end   <= i_item.frame_end;

            r_s2_lq    <= {13'd0, r_s1_ln} * {15'd0, RECIP_100};
            r_s2_uq    <= {13'd0, r_s1_un} * {15'd0, RECIP_100};
            r_s2_vq    <= {13'd0, r_s1_vn} * {15'd0, RECIP_100};
            r_s2_lidx  <= n_lidx[LIDX_W-1:0];
            r_s2_cidx  <= n_cidx[CIDX_W-1:0];
            r_s2_cv    <= r_s1_cv;
            r_s2_end   <= r_s1_end;

            o_luma         <= r_s2_lq[RECIP_SH +: PIX_W];
            o_luma_index   <= r_s2_lidx;
            o_chroma_valid <= r_s2_cv;
            o_chroma_u     <= r_s2_cv ? r_s2_uq[RECIP_SH +: PIX_W] : '0;
            o_chroma_v     <= r_s2_cv ? r_s2_vq[RECIP_SH +: PIX_W] : '0;
            o_chroma_index <= r_s2_cv ? r_s2_cidx : '0;
            o_frame_end    <= r_s2_end;
        end
    end

endmodule

[hw/rtl/rgb_to_yuv420_planar.sv]
`timescale 1ns / 1ps
// Throughput: one pixel per clock while i_ready is high; the two-entry queue
// and a three-stage back pipeline (numerators, reciprocal multiply, output register)
// set that figure. An accepted pixel passes the queue, then those stages in order.
// Reset (synchronous, active low) returns size registers to 352x288, restarts the
// frame at column and row zero and empties the queue and pipeline.
module rgb_to_yuv420_planar #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [r2y_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [r2y_pkg::SIZE_W-1:0]     i_cfg_data,
    output logic                           o_cfg_ready,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [r2y_pkg::PIX_W-1:0]      i_red,
    input  logic [r2y_pkg::PIX_W-1:0]      i_green,
    input  logic [r2y_pkg::PIX_W-1:0]      i_blue,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [r2y_pkg::PIX_W-1:0]      o_luma,
    output logic [r2y_pkg::LIDX_W-1:0]     o_luma_index,
    output logic                           o_chroma_valid,
    output logic [r2y_pkg::PIX_W-1:0]      o_chroma_u,
    output logic [r2y_pkg::PIX_W-1:0]      o_chroma_v,
    output logic [r2y_pkg::CIDX_W-1:0]     o_chroma_index,
    output logic                           o_frame_end
);
    import r2y_pkg::*;

    t_item     push_item;
    t_item     head_item;
    t_q_status q_status;
    logic      push;
    logic      pop;

    // Front: size registers, raster position, classification
    r2y_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_item      (push_item)
    );

    // Decoupling queue
    r2y_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (push_item),
        .i_pop    (pop),
        .o_item   (head_item),
        .o_status (q_status)
    );

    // Back: colour conversion and plane indexes
    r2y_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (head_item),
        .i_q_status     (q_status),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_luma         (o_luma),
        .o_luma_index   (o_luma_index),
        .o_chroma_valid (o_chroma_valid),
        .o_chroma_u     (o_chroma_u),
        .o_chroma_v     (o_chroma_v),
        .o_chroma_index (o_chroma_index),
        .o_frame_end    (o_frame_end)
    );

endmodule

[bench/rgb_to_yuv420_planar_test.sv]
`timescale 1ns / 1ps

module rgb_to_yuv420_planar_test;
    import r2y_pkg::*;

    localparam int          MAX_W         = 1024;
    localparam int          MAX_H         = 1024;
    localparam int          SETTLE_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam int          RANDOM_ITEMS  = 1400;

    // Indexes past the end of the register list: writes there are dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_TOP = 8'hFF;

    typedef struct packed {
        logic [PIX_W-1:0]  luma;
        logic [LIDX_W-1:0] luma_index;
        logic              chroma_valid;
        logic [PIX_W-1:0]  chroma_u;
        logic [PIX_W-1:0]  chroma_v;
        logic [CIDX_W-1:0] chroma_index;
        logic              frame_end;
    } t_yuv_result;

    typedef enum logic [1:0] {ROW_PIXEL, ROW_CONFIG} t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] cfg_index;
        logic [SIZE_W-1:0]    cfg_data;
        logic [PIX_W-1:0]     red;
        logic [PIX_W-1:0]     green;
        logic [PIX_W-1:0]     blue;
        logic                 typed;
        t_yuv_result          want;
    } t_stim_row;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_LONG} t_rx_mode;
    typedef enum logic [1:0] {CFG_BOTH, CFG_WIDTH_ONLY, CFG_HEIGHT_ONLY, CFG_IGNORED} t_cfg_plan;

    // DUT ports, all inputs known from time zero
    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index    = '0;
    logic [SIZE_W-1:0]    i_cfg_data     = '0;
    logic                 o_cfg_ready;
    logic                 i_valid        = 1'b0;
    logic                 o_ready;
    logic [PIX_W-1:0]     i_red          = '0;
    logic [PIX_W-1:0]     i_green        = '0;
    logic [PIX_W-1:0]     i_blue         = '0;
    logic                 o_valid;
    logic                 i_ready        = 1'b0;
    logic [PIX_W-1:0]     o_luma;
    logic [LIDX_W-1:0]    o_luma_index;
    logic                 o_chroma_valid;
    logic [PIX_W-1:0]     o_chroma_u;
    logic [PIX_W-1:0]     o_chroma_v;
    logic [CIDX_W-1:0]    o_chroma_index;
    logic                 o_frame_end;

    // Predictor state
    logic [SIZE_W-1:0] width_reg  = RST_WIDTH;
    logic [SIZE_W-1:0] height_reg = RST_HEIGHT;
    int unsigned       next_col   = 0;
    int unsigned       next_row   = 0;

    t_yuv_result pending_results [$];
    t_stim_row   directed_rows [$];

    int unsigned cycle_count   = 0;
    int          pixels_sent   = 0;
    int          cfg_writes    = 0;
    int          results_seen  = 0;
    int          chroma_seen   = 0;
    int          frames_seen   = 0;
    int          mismatch_count = 0;
    t_rx_mode    rx_mode       = RX_OPEN;
    int          rx_hold       = 0;

    rgb_to_yuv420_planar #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_cfg_ready    (o_cfg_ready),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_red          (i_red),
        .i_green        (i_green),
        .i_blue         (i_blue),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_luma         (o_luma),
        .o_luma_index   (o_luma_index),
        .o_chroma_valid (o_chroma_valid),
        .o_chroma_u     (o_chroma_u),
        .o_chroma_v     (o_chroma_v),
        .o_chroma_index (o_chroma_index),
        .o_frame_end    (o_frame_end)
    );

    // 50 MHz clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Size register as the block sees it: even, at least 2, at most the maximum
    function automatic int unsigned eff_size(input logic [SIZE_W-1:0] size_reg,
                                             input int unsigned limit);
        int unsigned s;
        int unsigned lim;
        s   = int'(size_reg) & 32'h7FE;
        lim = limit & ~32'd1;
        if (s < 2) s = 2;
        if (s > lim) s = lim;
        return s;
    endfunction

    // Converts one pixel at the tracked position and advances the raster
    function automatic t_yuv_result predict_pixel(input logic [PIX_W-1:0] r, g, b);
        t_yuv_result res;
        int unsigned w, h, ri, gi, bi;
        w  = eff_size(width_reg, MAX_W);
        h  = eff_size(height_reg, MAX_H);
        ri = r;
        gi = g;
        bi = b;
        res = '0;
        res.luma         = PIX_W'((30 * ri + 59 * gi + 11 * bi) / 100);
        res.luma_index   = LIDX_W'(next_row * w + next_col);
        res.chroma_valid = next_col[0] & next_row[0];
        if (res.chroma_valid) begin
            res.chroma_u     = PIX_W'((50 * bi + 12800 - 17 * ri - 33 * gi) / 100);
            res.chroma_v     = PIX_W'((50 * ri + 12800 - 42 * gi - 8 * bi) / 100);
            res.chroma_index = CIDX_W'((next_row >> 1) * (w >> 1) + (next_col >> 1));
        end
        res.frame_end = (next_col + 1 >= w) && (next_row + 1 >= h);
        if (next_col + 1 >= w) begin
            next_col = 0;
            next_row = (next_row + 1 >= h) ? 0 : next_row + 1;
        end else begin
            next_col = next_col + 1;
        end
        return res;
    endfunction

    function automatic t_yuv_result res_of(input int luma, lidx, cv, u, v, cidx, fe);
        t_yuv_result res;
        res.luma         = PIX_W'(luma);
        res.luma_index   = LIDX_W'(lidx);
        res.chroma_valid = cv[0];
        res.chroma_u     = PIX_W'(u);
        res.chroma_v     = PIX_W'(v);
        res.chroma_index = CIDX_W'(cidx);
        res.frame_end    = fe[0];
        return res;
    endfunction

    function automatic t_stim_row pix_row(input int r, g, b);
        t_stim_row row;
        row       = '0;
        row.kind  = ROW_PIXEL;
        row.red   = PIX_W'(r);
        row.green = PIX_W'(g);
        row.blue  = PIX_W'(b);
        return row;
    endfunction

    function automatic t_stim_row pix_known(input int r, g, b, input t_yuv_result want);
        t_stim_row row;
        row       = pix_row(r, g, b);
        row.typed = 1'b1;
        row.want  = want;
        return row;
    endfunction

    function automatic t_stim_row cfg_row(input logic [CFG_IDX_W-1:0] idx, input int data);
        t_stim_row row;
        row           = '0;
        row.kind      = ROW_CONFIG;
        row.cfg_index = idx;
        row.cfg_data  = SIZE_W'(data);
        return row;
    endfunction

    // Mostly small frames so that frame ends come often
    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return SIZE_W'($urandom_range(0, 12));
            6, 7:             return SIZE_W'($urandom_range(2, 40));
            8:                return SIZE_W'($urandom_range(0, 2047));
            default: begin
                case ($urandom_range(0, 4))
                    0:       return SIZE_W'(1024);
                    1:       return SIZE_W'(1025);
                    2:       return SIZE_W'(2047);
                    3:       return SIZE_W'(0);
                    default: return SIZE_W'(1);
                endcase
            end
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] pick_component();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Hold the pixel side off until every pending result is out
    task automatic settle_block();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [SIZE_W-1:0] data);
        settle_block();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
        if (idx == REG_FRAME_WIDTH) begin
            width_reg = data;
            next_col  = 0;
            next_row  = 0;
        end else if (idx == REG_FRAME_HEIGHT) begin
            height_reg = data;
            next_col   = 0;
            next_row   = 0;
        end
    endtask

    // Presents one pixel and leaves valid high once it is taken
    task automatic send_pixel(input logic [PIX_W-1:0] r, g, b,
                              input logic typed, input t_yuv_result want);
        t_yuv_result pred;
        i_valid <= 1'b1;
        i_red   <= r;
        i_green <= g;
        i_blue  <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pred = predict_pixel(r, g, b);
        pending_results.push_back(typed ? want : pred);
        pixels_sent++;
    endtask

    task automatic gap_cycles(input int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Receiver stall pattern; a new random mode is drawn whenever cycle_count % 256 is zero
    always @(posedge i_clk) begin : rx_stall
        logic ready_next;
        if (cycle_count % 256 == 0) rx_mode = t_rx_mode'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN:     ready_next = 1'b1;
            RX_RANDOM:   ready_next = ($urandom_range(0, 9) < 7);
            RX_PERIODIC: ready_next = (cycle_count % 3 != 0);
            default: begin
                if (rx_hold > 0) begin
                    rx_hold--;
                    ready_next = 1'b0;
                end else begin
                    ready_next = 1'b1;
                    if ($urandom_range(0, 15) == 0) rx_hold = $urandom_range(1, 15);
                end
            end
        endcase
        i_ready <= ready_next;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result checker
    always @(posedge i_clk) begin : result_check
        t_yuv_result got;
        t_yuv_result want;
        if (i_rst_n && o_valid && i_ready) begin
            got.luma         = o_luma;
            got.luma_index   = o_luma_index;
            got.chroma_valid = o_chroma_valid;
            got.chroma_u     = o_chroma_u;
            got.chroma_v     = o_chroma_v;
            got.chroma_index = o_chroma_index;
            got.frame_end    = o_frame_end;
            results_seen++;
            if (o_chroma_valid) chroma_seen++;
            if (o_frame_end) frames_seen++;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %0d: Y=%0d idx=%0d", results_seen,
                             o_luma, o_luma_index);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch at result %0d, expected: Y=%0d idx=%0d cv=%0b",
                                 results_seen, want.luma, want.luma_index,
                                 want.chroma_valid);
                        $display("    U=%0d V=%0d cidx=%0d end=%0b; got: Y=%0d idx=%0d cv=%0b",
                                 want.chroma_u, want.chroma_v, want.chroma_index,
                                 want.frame_end, got.luma, got.luma_index,
                                 got.chroma_valid);
                        $display("    U=%0d V=%0d cidx=%0d end=%0b",
                                 got.chroma_u, got.chroma_v, got.chroma_index,
                                 got.frame_end);
                    end
                end
            end
        end
    end

    // Stimulus
    initial begin : stimulus
        t_stim_row   row;
        t_cfg_plan   plan;
        int unsigned w, h;
        int          count, burst_left, phase, random_sent;
        bit          drain_mid;

        // Directed table: reset size first, then the 2x2 frame, then size extremes
        directed_rows.push_back(pix_known(0, 0, 0, res_of(0, 0, 0, 0, 0, 0, 0)));
        directed_rows.push_back(pix_known(255, 255, 255, res_of(255, 1, 0, 0, 0, 0, 0)));
        directed_rows.push_back(cfg_row(REG_FRAME_WIDTH, 2));
        directed_rows.push_back(cfg_row(REG_FRAME_HEIGHT, 2));
        directed_rows.push_back(pix_known(0, 0, 0, res_of(0, 0, 0, 0, 0, 0, 0)));
        directed_rows.push_back(pix_known(255, 255, 255, res_of(255, 1, 0, 0, 0, 0, 0)));
        directed_rows.push_back(pix_known(255, 0, 0, res_of(76, 2, 0, 0, 0, 0, 0)));
        directed_rows.push_back(pix_known(0, 0, 255, res_of(28, 3, 1, 255, 107, 0, 1)));
        directed_rows.push_back(pix_known(0, 255, 0, res_of(150, 0, 0, 0, 0, 0, 0)));
        directed_rows.push_back(pix_row(255, 255, 0));
        directed_rows.push_back(pix_row(0, 255, 0));
        directed_rows.push_back(pix_row(255, 255, 0));     // lowest U
        // too small sizes fall back to 2
        directed_rows.push_back(cfg_row(REG_FRAME_WIDTH, 0));
        directed_rows.push_back(cfg_row(REG_FRAME_HEIGHT, 1));
        directed_rows.push_back(pix_row(128, 64, 32));
        directed_rows.push_back(pix_row(7, 8, 9));
        directed_rows.push_back(pix_row(200, 100, 50));
        directed_rows.push_back(pix_row(0, 255, 255));     // lowest V
        // saturated width, odd height, then dropped writes mid-frame
        directed_rows.push_back(cfg_row(REG_FRAME_WIDTH, 2047));
        directed_rows.push_back(cfg_row(REG_FRAME_HEIGHT, 3));
        directed_rows.push_back(pix_row(8'h55, 8'hAA, 8'h55));
        directed_rows.push_back(pix_row(8'hAA, 8'h55, 8'hAA));
        directed_rows.push_back(cfg_row(REG_UNUSED_TOP, 2047));
        directed_rows.push_back(cfg_row(REG_UNUSED_LOW, 11'h555));
        directed_rows.push_back(pix_row(1, 2, 3));
        directed_rows.push_back(pix_row(254, 253, 252));
        directed_rows.push_back(cfg_row(REG_FRAME_WIDTH, 1025));
        directed_rows.push_back(cfg_row(REG_FRAME_HEIGHT, 2047));
        directed_rows.push_back(pix_row(0, 0, 0));

        // Reset
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            if (row.kind == ROW_CONFIG) begin
                write_register(row.cfg_index, row.cfg_data);
            end else begin
                send_pixel(row.red, row.green, row.blue, row.typed, row.want);
                if ($urandom_range(0, 2) == 0) gap_cycles($urandom_range(1, 3));
            end
        end

        // Random phases, each opened by its own register writes
        random_sent = 0;
        phase       = 0;
        while (random_sent < RANDOM_ITEMS) begin
            if (phase == 2) begin
                write_register(REG_FRAME_WIDTH, SIZE_W'(1024));
                write_register(REG_FRAME_HEIGHT, SIZE_W'(2));
            end else if (phase == 5) begin
                write_register(REG_FRAME_WIDTH, SIZE_W'(2));
                write_register(REG_FRAME_HEIGHT, SIZE_W'(1024));
            end else begin
                plan = t_cfg_plan'($urandom_range(0, 3));
                case (plan)
                    CFG_BOTH: begin
                        write_register(REG_FRAME_WIDTH, pick_size());
                        write_register(REG_FRAME_HEIGHT, pick_size());
                    end
                    CFG_WIDTH_ONLY:  write_register(REG_FRAME_WIDTH, pick_size());
                    CFG_HEIGHT_ONLY: write_register(REG_FRAME_HEIGHT, pick_size());
                    default: write_register(CFG_IDX_W'($urandom_range(REG_UNUSED_LOW,
                                                                      REG_UNUSED_TOP)),
                                            SIZE_W'($urandom_range(0, 2047)));
                endcase
            end

            w = eff_size(width_reg, MAX_W);
            h = eff_size(height_reg, MAX_H);
            if (phase == 2) begin
                count = 1024 + 6;              // one full line at the widest width, then on
            end else begin
                count = w * h * $urandom_range(1, 3) + $urandom_range(0, 7);
                if (count > 150) count = $urandom_range(20, 150);
            end
            drain_mid = (phase == 0) || ($urandom_range(0, 3) == 0);

            burst_left = $urandom_range(1, 24);
            for (int n = 0; n < count; n++) begin
                if (drain_mid && n == count / 2) settle_block();
                send_pixel(pick_component(), pick_component(), pick_component(),
                           1'b0, '0);
                random_sent++;
                burst_left--;
                if (burst_left == 0) begin
                    gap_cycles($urandom_range(1, 8));
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                             : $urandom_range(1, 12);
                end
            end
            phase++;
        end

        // Wind down
        settle_block();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Sent %0d pixels in %0d phases with %0d register writes",
                 pixels_sent, phase, cfg_writes);
        $display("Checked %0d results: %0d chroma samples, %0d frame ends, %0d mismatches",
                 results_seen, chroma_seen, frames_seen, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[rgb_to_yuv420_planar.f]
hw/rtl/r2y_pkg.sv
hw/rtl/r2y_front.sv
hw/rtl/r2y_queue.sv
hw/rtl/r2y_back.sv
hw/rtl/rgb_to_yuv420_planar.sv
bench/rgb_to_yuv420_planar_test.sv
